[design/vps_pkg.sv]
package vps_pkg;

  // Default number of list entries.
  localparam int unsigned DefaultListDepth = 8;

  // Field widths fixed by the item format.
  localparam int unsigned IdW    = 16;
  localparam int unsigned PriW   = 32;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned CountW = 4;

  // Command codes.
  localparam logic [CmdW-1:0] CMD_UPDATE = 2'd0;
  localparam logic [CmdW-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CmdW-1:0] CMD_CLEAR  = 2'd2;

  // One stored list entry.
  typedef struct packed {
    logic [IdW-1:0]         id;
    logic signed [PriW-1:0] pri;
  } entry_t;

endpackage

[design/vps_in_if.sv]
interface vps_in_if;
  import vps_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CmdW-1:0]        cmd;
  logic                   into_object;
  logic                   transmit;
  logic                   is_volume_event;
  logic [IdW-1:0]         inner_id;
  logic signed [PriW-1:0] inner_priority;
  logic [IdW-1:0]         outer_id;

  modport source (
    output valid, cmd, into_object, transmit, is_volume_event,
    output inner_id, inner_priority, outer_id,
    input  ready
  );

  modport sink (
    input  valid, cmd, into_object, transmit, is_volume_event,
    input  inner_id, inner_priority, outer_id,
    output ready
  );
endinterface

[design/vps_out_if.sv]
interface vps_out_if;
  import vps_pkg::*;

  logic              valid;
  logic              ready;
  logic [IdW-1:0]    current_id;
  logic              scattered_flag;
  logic              keep_tracing;
  logic [IdW-1:0]    hit_inner_id;
  logic [IdW-1:0]    hit_outer_id;
  logic [CountW-1:0] stack_count;

  modport source (
    output valid, current_id, scattered_flag, keep_tracing,
    output hit_inner_id, hit_outer_id, stack_count,
    input  ready
  );

  modport sink (
    input  valid, current_id, scattered_flag, keep_tracing,
    input  hit_inner_id, hit_outer_id, stack_count,
    output ready
  );
endinterface

[design/volume_priority_stack.sv]
// Volume priority list for a path tracer.
// Items arrive on in_i (valid/ready) and one result beat per item leaves on
// out_o (valid/ready). The user sets the world volume id through cfg_we_i and
// cfg_wdata_i while the block is idle; the block does not enforce this.
// The list entries live in a single memory with a registered read port.
// Updates that add, mark a scatter or do nothing, clears, queries on entry and
// exit queries with no inner id or an empty list finish in the accept cycle:
// the result is registered and shown the next cycle.
// An exit removal and an exit query walk the list through the memory read
// port, one entry per cycle, compacting the list behind a removed entry
// through the write port. In the scan state the block issues one read per
// entry and takes in the last read once it returns; the finish state then
// loads the result, waiting while the result register is full.
// One item is in work at a time; in_i.ready is low while a walk runs or
// while the result register is full and out_o.ready is low.
// A receiver stall holds the result beat and, from there, the input side.
// Reset empties the list, clears the current volume, the scatter mark and
// the world volume id; no memory clearing pass is needed.
module volume_priority_stack #(
  parameter int unsigned LIST_DEPTH = vps_pkg::DefaultListDepth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [vps_pkg::IdW-1:0] cfg_wdata_i,
  vps_in_if.sink                 in_i,
  vps_out_if.source              out_o
);
  import vps_pkg::*;

  localparam int unsigned IdxW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(LIST_DEPTH + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  // Architectural state.
  logic [1:0]             state_q, state_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [IdW-1:0]         top_id_q, top_id_d;
  logic signed [PriW-1:0] top_pri_q, top_pri_d;
  logic                   scatter_q, scatter_d;
  logic [IdW-1:0]         world_q;

  // Walk state.
  logic [CntW-1:0]        rd_idx_q, rd_idx_d;
  logic [CntW-1:0]        pidx_q, pidx_d;
  logic                   pend_q, pend_d;
  logic                   found_q, found_d;
  logic [IdW-1:0]         best_id_q, best_id_d;
  logic signed [PriW-1:0] best_pri_q, best_pri_d;
  logic                   op_remove_q, op_remove_d;
  logic                   op_tr_q, op_tr_d;
  logic [IdW-1:0]         skip_q, skip_d;

  // Entry memory.
  entry_t                 mem [LIST_DEPTH];
  entry_t                 rdata_q;
  logic                   mem_we;
  logic [IdxW-1:0]        mem_wa;
  entry_t                 mem_wd;
  logic [IdxW-1:0]        mem_ra;

  // Result register.
  logic                   out_valid_q, out_valid_d;
  logic                   out_load;
  logic [IdW-1:0]         res_cur, res_hin, res_hout;
  logic                   res_scat, res_keep;
  logic [CntW-1:0]        res_cnt;
  logic [IdW-1:0]         cur_q, hin_q, hout_q;
  logic                   scat_q, keep_q;
  logic [CntW-1:0]        cnt_q;

  logic                   out_free;
  logic                   accept;
  logic [CntW-1:0]        comp_idx;
  logic [IdW-1:0]         sim_add;
  logic [IdW-1:0]         hout_pre, hin_pre;

  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign accept = in_i.valid && in_i.ready;
  assign comp_idx = pidx_q - CntW'(1);

  // Memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[mem_ra];
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      world_q <= '0;
    end else if (cfg_we_i) begin
      world_q <= cfg_wdata_i;
    end
  end

  // Immediate query answers for an entering ray and for an exit query that needs no walk.
  always_comb begin
    if (top_id_q != '0) begin
      if (in_i.inner_id != '0) begin
        sim_add = (top_pri_q > in_i.inner_priority) ? top_id_q : in_i.inner_id;
      end else begin
        sim_add = top_id_q;
      end
    end else begin
      sim_add = in_i.inner_id;
    end
    hout_pre = (top_id_q != '0) ? top_id_q : in_i.outer_id;
    hin_pre  = (top_id_q != '0) ? top_id_q : in_i.inner_id;
  end

  // Sequencer and list update.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    top_id_d    = top_id_q;
    top_pri_d   = top_pri_q;
    scatter_d   = scatter_q;
    rd_idx_d    = rd_idx_q;
    pidx_d      = pidx_q;
    pend_d      = pend_q;
    found_d     = found_q;
    best_id_d   = best_id_q;
    best_pri_d  = best_pri_q;
    op_remove_d = op_remove_q;
    op_tr_d     = op_tr_q;
    skip_d      = skip_q;
    mem_we      = 1'b0;
    mem_wa      = count_q[IdxW-1:0];
    mem_wd      = '0;
    mem_ra      = rd_idx_q[IdxW-1:0];
    out_load    = 1'b0;
    res_cur     = top_id_q;
    res_scat    = scatter_q;
    res_keep    = 1'b0;
    res_hin     = '0;
    res_hout    = '0;
    res_cnt     = count_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          // Prepare a walk in case this item needs one.
          rd_idx_d    = '0;
          pend_d      = 1'b0;
          found_d     = 1'b0;
          best_id_d   = '0;
          best_pri_d  = '0;
          skip_d      = in_i.inner_id;
          op_tr_d     = in_i.transmit;
          op_remove_d = 1'b0;
          out_load    = 1'b1;
          unique case (in_i.cmd)
            CMD_UPDATE: begin
              if (in_i.is_volume_event) begin
                scatter_d = 1'b1;
              end else begin
                scatter_d = 1'b0;
                if (in_i.transmit && in_i.into_object) begin
                  // Add at the end of the list.
                  if (in_i.inner_id != '0 && count_q != CntW'(LIST_DEPTH)) begin
                    mem_we = 1'b1;
                    mem_wa = count_q[IdxW-1:0];
                    mem_wd = '{id: in_i.inner_id, pri: in_i.inner_priority};
                    count_d = count_q + CntW'(1);
                    if (top_id_q == '0 || in_i.inner_priority >= top_pri_q) begin
                      top_id_d  = in_i.inner_id;
                      top_pri_d = in_i.inner_priority;
                    end
                  end
                end else if (in_i.transmit && in_i.inner_id != '0 && count_q != '0) begin
                  // Remove needs a walk over the list.
                  op_remove_d = 1'b1;
                  out_load    = 1'b0;
                  state_d     = ST_SCAN;
                end
              end
              res_cur  = top_id_d;
              res_scat = scatter_d;
              res_cnt  = count_d;
            end
            CMD_QUERY: begin
              if (in_i.into_object) begin
                res_keep = in_i.transmit && top_id_q != '0 && in_i.inner_id != '0 &&
                           (top_id_q == in_i.inner_id ||
                            top_pri_q > in_i.inner_priority);
                res_hin  = sim_add;
                res_hout = (hout_pre != '0) ? hout_pre : world_q;
              end else if (in_i.inner_id != '0 && count_q != '0) begin
                // Exit query needs a simulated removal walk.
                out_load = 1'b0;
                state_d  = ST_SCAN;
              end else begin
                res_keep = in_i.transmit && top_id_q != '0;
                res_hin  = (hin_pre != '0) ? hin_pre : world_q;
                res_hout = top_id_q;
              end
            end
            CMD_CLEAR: begin
              count_d   = '0;
              top_id_d  = '0;
              top_pri_d = '0;
              res_cur   = '0;
              res_cnt   = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Issue the next read.
        if (rd_idx_q != count_q) begin
          rd_idx_d = rd_idx_q + CntW'(1);
          pend_d   = 1'b1;
          pidx_d   = rd_idx_q;
        end else begin
          pend_d   = 1'b0;
          state_d  = ST_FINISH;
        end
        // Process the entry read in the previous cycle.
        if (pend_q) begin
          if (!found_q && rdata_q.id == skip_q) begin
            found_d = 1'b1;
          end else if (best_id_q == '0 || rdata_q.pri >= best_pri_q) begin
            best_id_d  = rdata_q.id;
            best_pri_d = rdata_q.pri;
          end
          // Compaction: move entries after the match down by one.
          if (found_q && op_remove_q) begin
            mem_we = 1'b1;
            mem_wa = comp_idx[IdxW-1:0];
            mem_wd = rdata_q;
          end
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          if (op_remove_q) begin
            if (found_q) begin
              count_d = count_q - CntW'(1);
            end
            top_id_d  = best_id_q;
            top_pri_d = best_pri_q;
            res_cur   = best_id_q;
            res_cnt   = count_d;
          end else begin
            res_keep = op_tr_q && top_id_q != '0 && best_id_q == top_id_q;
            res_hin  = (top_id_q != '0) ? top_id_q :
                       ((skip_q != '0) ? skip_q : world_q);
            res_hout = best_id_q;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid tracking.
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      top_id_q    <= '0;
      top_pri_q   <= '0;
      scatter_q   <= 1'b0;
      rd_idx_q    <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      op_remove_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      top_id_q    <= top_id_d;
      top_pri_q   <= top_pri_d;
      scatter_q   <= scatter_d;
      rd_idx_q    <= rd_idx_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
      op_remove_q <= op_remove_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Walk payload registers.
  always_ff @(posedge clk_i) begin
    pidx_q     <= pidx_d;
    best_id_q  <= best_id_d;
    best_pri_q <= best_pri_d;
    op_tr_q    <= op_tr_d;
    skip_q     <= skip_d;
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      cur_q  <= res_cur;
      scat_q <= res_scat;
      keep_q <= res_keep;
      hin_q  <= res_hin;
      hout_q <= res_hout;
      cnt_q  <= res_cnt;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.current_id     = cur_q;
  assign out_o.scattered_flag = scat_q;
  assign out_o.keep_tracing   = keep_q;
  assign out_o.hit_inner_id   = hin_q;
  assign out_o.hit_outer_id   = hout_q;
  assign out_o.stack_count    = CountW'(cnt_q);

endmodule
